[sv/nqueens_constellation_counter_assert.svh]
// assertion macros shared by the counter rtl
`ifndef NQUEENS_CONSTELLATION_COUNTER_ASSERT_SVH
`define NQUEENS_CONSTELLATION_COUNTER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define NQC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nqc assertion failed");

// next-cycle implication, checked outside reset
`define NQC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nqc assertion failed");

`endif

[sv/nqc_pkg.sv]
// shared types, constants and the row mask function
package nqc_pkg;

  localparam int BOARD_N = 16;
  localparam int ROW_W = $clog2(BOARD_N);
  localparam int TALLY_W = 48;
  localparam logic [31:0] BORDER_BIT = 32'h1 << (BOARD_N - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(BOARD_N - 2);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RUN,
    ST_DONE
  } nqc_state_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stack_ctl_t;

  // blocked columns of row a for border queens j, k, l (shifts mod 32)
  function automatic logic [31:0] row_mask(input logic [4:0] a, input logic [4:0] j,
                                           input logic [4:0] k, input logic [4:0] l);
    logic [31:0] ldb;
    logic [31:0] rdb;
    logic [31:0] ldt;
    logic [31:0] rdt;
    logic [31:0] m;
    logic [4:0] na;
    logic [4:0] nk;
    na = 5'(BOARD_N - 1) - a;
    nk = 5'(BOARD_N - 1) - k;
    ldb = (BORDER_BIT >> j) | (BORDER_BIT >> l);
    rdb = (BORDER_BIT >> j) | (BORDER_BIT >> nk);
    ldt = BORDER_BIT >> k;
    rdt = 32'h1 << l;
    if (a == k || a == l) begin
      m = '0;
      if (a == k) m = m + ~BORDER_BIT;
      if (a == l) m = m + ~32'h1;
    end else begin
      m = (ldb >> na) | (rdb << na) | (ldt << a) | (rdt >> a) | BORDER_BIT | 32'h1;
    end
    return m;
  endfunction

endpackage

[sv/nqc_if.sv]
// valid/ready channel interfaces for constellations and counts
interface nqc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] left_diagonals;
  logic [31:0] right_diagonals;
  logic [31:0] occupied_columns;
  logic [4:0]  start_row;
  logic [4:0]  queen_j_row;
  logic [4:0]  queen_k_row;
  logic [4:0]  queen_l_row;
  logic        pseudo_entry;

  modport source (output valid, left_diagonals, right_diagonals, occupied_columns,
                  start_row, queen_j_row, queen_k_row, queen_l_row, pseudo_entry,
                  input ready);
  modport sink (input valid, left_diagonals, right_diagonals, occupied_columns,
                start_row, queen_j_row, queen_k_row, queen_l_row, pseudo_entry,
                output ready);
endinterface

interface nqc_out_if;
  logic        valid;
  logic        ready;
  logic [47:0] solution_count;

  modport source (output valid, solution_count, input ready);
  modport sink (input valid, solution_count, output ready);
endinterface

[sv/nqc_stack_cell.sv]
// one cell of the queen stack shift chain
module nqc_stack_cell import nqc_pkg::*; (
  input  logic               clk,
  input  stack_ctl_t         ctl,
  input  logic [BOARD_N-1:0] above_q,
  input  logic [BOARD_N-1:0] below_q,
  output logic [BOARD_N-1:0] q
);

  logic [BOARD_N-1:0] q_r;

  // push takes the neighbor above, pop the neighbor below
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      q_r <= above_q;
    end else if (ctl.pop) begin
      q_r <= below_q;
    end
  end

  assign q = q_r;

endmodule

[sv/nqc_mask_cell.sv]
// one row of the per-item row mask table
module nqc_mask_cell import nqc_pkg::*; (
  input  logic               clk,
  input  logic               load,
  input  logic [4:0]         cell_idx,
  input  logic [4:0]         j_row,
  input  logic [4:0]         k_row,
  input  logic [4:0]         l_row,
  output logic [BOARD_N-1:0] mask
);

  logic [31:0]        full_mask;
  logic [BOARD_N-1:0] mask_r;

  assign full_mask = row_mask(cell_idx, j_row, k_row, l_row);

  always_ff @(posedge clk) begin
    if (load) begin
      mask_r <= full_mask[BOARD_N-1:0];
    end
  end

  assign mask = mask_r;

endmodule

[sv/nqueens_constellation_counter.sv]
// top level: n-queens constellation solution counter
// Counts the completions of one N-queens constellation per transfer. The row masks are
// loaded on the input transfer and the load state sets up the first free columns; the block
// then visits one search node per cycle (a step forward or a step back) until a step back
// is due at start_row, and then hands the count to the result register. A pseudo entry or
// a start row beyond the counting row skips the search and goes straight to the result.
// The single node step, driven by a stack of queen cells that shift as a chain, sets this
// rate. One item is searched at a time; the next item is taken once the count is handed
// to the result register, which then waits for its transfer on its own.
module nqueens_constellation_counter import nqc_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  nqc_in_if.sink    in_chan,
  nqc_out_if.source out_chan
);

`include "nqueens_constellation_counter_assert.svh"

  nqc_state_t         state_r, state_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [ROW_W-1:0]   start_r, start_nxt;
  logic [31:0]        ldw_r, ldw_nxt;
  logic [31:0]        rdw_r, rdw_nxt;
  logic [31:0]        col_r, col_nxt;
  logic [31:0]        lo_r, lo_nxt;
  logic [31:0]        ro_r, ro_nxt;
  logic [BOARD_N-1:0] free_r, free_nxt;
  logic [TALLY_W-1:0] tally_r, tally_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [TALLY_W-1:0] out_count_r, out_count_nxt;

  stack_ctl_t         stack_ctl;
  logic [BOARD_N-1:0] push_q;
  logic [BOARD_N-1:0] stack_q [BOARD_N];
  logic [BOARD_N-1:0] mask_q [BOARD_N];
  logic               mask_load;
  logic               in_ready;

  // search step temporaries
  logic [BOARD_N-1:0] q_fwd;
  logic [BOARD_N-1:0] q_sel;
  logic [31:0]        q_wide;
  logic [BOARD_N-1:0] keep;
  logic [ROW_W-1:0]   row_new;
  logic [31:0]        occ_new;

  assign q_fwd = free_r & (~free_r + BOARD_N'(1));

  // row mask table, one cell per board row, loaded on the input transfer
  for (genvar gi = 0; gi < BOARD_N; gi++) begin : g_mask
    nqc_mask_cell u_mask (
      .clk      (clk),
      .load     (mask_load),
      .cell_idx (5'(gi)),
      .j_row    (in_chan.queen_j_row),
      .k_row    (in_chan.queen_k_row),
      .l_row    (in_chan.queen_l_row),
      .mask     (mask_q[gi])
    );
  end

  // queen stack: cell 0 is the top, push shifts down, pop shifts up
  for (genvar gi = 0; gi < BOARD_N; gi++) begin : g_stack
    logic [BOARD_N-1:0] above_q;
    logic [BOARD_N-1:0] below_q;
    if (gi == 0) begin : g_top
      assign above_q = push_q;
    end else begin : g_mid
      assign above_q = stack_q[gi-1];
    end
    if (gi == BOARD_N - 1) begin : g_bot
      assign below_q = '0;
    end else begin : g_low
      assign below_q = stack_q[gi+1];
    end
    nqc_stack_cell u_cell (
      .clk     (clk),
      .ctl     (stack_ctl),
      .above_q (above_q),
      .below_q (below_q),
      .q       (stack_q[gi])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_r       <= '0;
      start_r     <= '0;
      ldw_r       <= '0;
      rdw_r       <= '0;
      col_r       <= '0;
      lo_r        <= '0;
      ro_r        <= '0;
      free_r      <= '0;
      tally_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      start_r     <= start_nxt;
      ldw_r       <= ldw_nxt;
      rdw_r       <= rdw_nxt;
      col_r       <= col_nxt;
      lo_r        <= lo_nxt;
      ro_r        <= ro_nxt;
      free_r      <= free_nxt;
      tally_r     <= tally_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload needs no reset
  always_ff @(posedge clk) begin
    out_count_r <= out_count_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    start_nxt     = start_r;
    ldw_nxt       = ldw_r;
    rdw_nxt       = rdw_r;
    col_nxt       = col_r;
    lo_nxt        = lo_r;
    ro_nxt        = ro_r;
    free_nxt      = free_r;
    tally_nxt     = tally_r;
    out_count_nxt = out_count_r;
    out_valid_nxt = out_valid_r;
    stack_ctl     = '0;
    push_q        = q_fwd;
    mask_load     = 1'b0;
    in_ready      = 1'b0;
    q_sel         = q_fwd;
    q_wide        = '0;
    keep          = '1;
    row_new       = row_r;
    occ_new       = '0;

    // result leaves on its transfer
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_chan.valid) begin
          mask_load = 1'b1;
          tally_nxt = '0;
          start_nxt = in_chan.start_row[ROW_W-1:0];
          row_nxt   = in_chan.start_row[ROW_W-1:0];
          lo_nxt    = '0;
          ro_nxt    = '0;
          // drop the k border diagonal, and the l one unless queen_l_row is the last row
          ldw_nxt = in_chan.left_diagonals &
                    ~((BORDER_BIT >> in_chan.queen_k_row) << in_chan.start_row);
          rdw_nxt = in_chan.right_diagonals;
          if (in_chan.queen_l_row != 5'(BOARD_N - 1)) begin
            rdw_nxt = in_chan.right_diagonals &
                      ~((32'h1 << in_chan.queen_l_row) >> in_chan.start_row);
          end
          col_nxt = ~(BORDER_BIT - 32'd2) ^ in_chan.occupied_columns;
          if (in_chan.pseudo_entry || in_chan.start_row > 5'(BOARD_N - 2)) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_LOAD;
          end
        end
      end

      ST_LOAD: begin
        occ_new   = ldw_r | rdw_r | col_r;
        free_nxt  = ~(occ_new[BOARD_N-1:0] | mask_q[row_r]);
        state_nxt = ST_RUN;
      end

      ST_RUN: begin
        if (free_r != '0 && row_r != ROW_LAST) begin
          // step forward: place lowest free queen, save diagonal overflow bits
          stack_ctl.push = 1'b1;
          q_sel   = q_fwd;
          q_wide  = 32'(q_fwd);
          row_new = row_r + ROW_W'(1);
          lo_nxt  = {lo_r[30:0], ldw_r[31]};
          ro_nxt  = {rdw_r[0], ro_r[31:1]};
          ldw_nxt = (ldw_r | q_wide) << 1;
          rdw_nxt = (rdw_r | q_wide) >> 1;
          keep    = ~q_fwd;
        end else begin
          if (free_r != '0) begin
            tally_nxt = tally_r + TALLY_W'(1);
          end
          q_sel   = stack_q[0];
          q_wide  = 32'(stack_q[0]);
          row_new = row_r - ROW_W'(1);
          keep    = ~(stack_q[0] - BOARD_N'(1));
          if (row_r == start_r) begin
            state_nxt = ST_DONE;
          end else begin
            // step back: pop the queen and restore the diagonals
            stack_ctl.pop = 1'b1;
            ldw_nxt = ({lo_r[0], ldw_r[31:1]}) & ~q_wide;
            rdw_nxt = ({rdw_r[30:0], ro_r[31]}) & ~q_wide;
            lo_nxt  = lo_r >> 1;
            ro_nxt  = ro_r << 1;
          end
        end
        if (state_nxt == ST_RUN) begin
          row_nxt  = row_new;
          occ_new  = ldw_nxt | rdw_nxt | col_r;
          free_nxt = ~(occ_new[BOARD_N-1:0] | mask_q[row_new]) & keep;
          col_nxt  = col_r ^ 32'(q_sel);
        end
      end

      ST_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = tally_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_chan.ready           = in_ready;
  assign out_chan.valid          = out_valid_r;
  assign out_chan.solution_count = out_count_r;

  // search never climbs past the counting row nor drops below the start row
  `NQC_ASSERT_SAME(a_row_bound, state_r == ST_RUN, row_r <= ROW_LAST && row_r >= start_r)
  // an input transfer always starts work
  `NQC_ASSERT_NEXT(a_accept_busy, in_chan.valid && in_chan.ready, state_r != ST_IDLE)
  // a new result only comes out of the finish state
  `NQC_ASSERT_NEXT(a_result_src, !out_valid_r, !out_valid_r || $past(state_r == ST_DONE))
  // stack never pushes and pops at once
  `NQC_ASSERT_SAME(a_stack_ctl, 1'b1, !(stack_ctl.push && stack_ctl.pop))

endmodule
